### sv/lnp_pkg.sv
// ----------------------------------------------------------------------------
// lnp_pkg
// Shared types, constants and the half-period table for the last-note-priority
// tone generator.
// ----------------------------------------------------------------------------
package lnp_pkg;

  localparam int NUM_KEYS    = 13;
  localparam int NUM_OCTAVES = 5;
  localparam int NOTE_W      = 4;
  localparam int OCT_W       = 3;
  localparam int PERIOD_W    = 16;
  localparam int ROM_IDX_W   = 7;

  localparam logic [OCT_W-1:0]  OCT_MAX   = 3'd4;
  localparam logic [OCT_W-1:0]  OCT_RESET = 3'd2;
  localparam logic [NOTE_W-1:0] LAST_KEY  = 4'd12;

  typedef struct packed {
    logic [NUM_KEYS-1:0] key_levels;
    logic                octave_down;
    logic                octave_up;
  } lnp_in_t;

  typedef struct packed {
    logic                wave_out;
    logic                tone_enabled;
    logic [NOTE_W-1:0]   active_note;
    logic [OCT_W-1:0]    active_octave;
    logic [PERIOD_W-1:0] half_period;
  } lnp_out_t;

  // shift command seen by every stack cell
  typedef struct packed {
    logic push;
    logic pop;
  } lnp_shift_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [NOTE_W-1:0] top;
  } lnp_stack_status_t;

  typedef struct packed {
    logic              step;
    logic              on;
    logic [NOTE_W-1:0] note;
    logic [OCT_W-1:0]  octave;
  } lnp_tone_req_t;

  typedef struct packed {
    logic                wave;
    logic                on;
    logic [PERIOD_W-1:0] half_period;
  } lnp_tone_stat_t;

  // octave-major, 13 notes per octave
  localparam logic [PERIOD_W-1:0] PERIOD_ROM [NUM_OCTAVES*NUM_KEYS] = '{
    16'd15288, 16'd14430, 16'd13620, 16'd12857, 16'd12134, 16'd11453, 16'd10811,
    16'd10204, 16'd9631,  16'd9091,  16'd8581,  16'd8099,  16'd7645,
    16'd7645,  16'd7215,  16'd6811,  16'd6428,  16'd6068,  16'd5727,  16'd5405,
    16'd5102,  16'd4816,  16'd4545,  16'd4290,  16'd4049,  16'd3822,
    16'd3822,  16'd3608,  16'd3405,  16'd3214,  16'd3034,  16'd2863,  16'd2703,
    16'd2551,  16'd2408,  16'd2272,  16'd2145,  16'd2025,  16'd1911,
    16'd1911,  16'd1804,  16'd1703,  16'd1607,  16'd1517,  16'd1432,  16'd1351,
    16'd1275,  16'd1204,  16'd1136,  16'd1073,  16'd1012,  16'd955,
    16'd955,   16'd902,   16'd851,   16'd803,   16'd758,   16'd716,   16'd676,
    16'd638,   16'd602,   16'd568,   16'd536,   16'd506,   16'd477
  };

  function automatic logic [PERIOD_W-1:0] period_lookup(
    input logic [OCT_W-1:0]  octave,
    input logic [NOTE_W-1:0] note
  );
    logic [ROM_IDX_W-1:0] idx;
    logic [PERIOD_W-1:0]  val;
    idx = ROM_IDX_W'(octave) * ROM_IDX_W'(NUM_KEYS) + ROM_IDX_W'(note);
    if (octave < OCT_W'(NUM_OCTAVES) && note < NOTE_W'(NUM_KEYS)) begin
      val = PERIOD_ROM[idx];
    end else begin
      val = '0;
    end
    return val;
  endfunction

endpackage

### sv/lnp_cell.sv
// ----------------------------------------------------------------------------
// lnp_cell
// One note-stack entry: takes the entry above on a push, the entry below on
// a pop, and holds otherwise.
// ----------------------------------------------------------------------------
module lnp_cell (
  input  logic                      clk,
  input  lnp_pkg::lnp_shift_t       shift,
  input  logic [lnp_pkg::NOTE_W-1:0] above_note,
  input  logic [lnp_pkg::NOTE_W-1:0] below_note,
  output logic [lnp_pkg::NOTE_W-1:0] note
);
  import lnp_pkg::*;

  logic [NOTE_W-1:0] note_r;
  logic [NOTE_W-1:0] note_nxt;

  always_comb begin
    priority if (shift.push) begin
      note_nxt = above_note;
    end else if (shift.pop) begin
      note_nxt = below_note;
    end else begin
      note_nxt = note_r;
    end
  end

  always_ff @(posedge clk) begin
    note_r <= note_nxt;
  end

  assign note = note_r;

endmodule

### sv/lnp_stack.sv
// ----------------------------------------------------------------------------
// lnp_stack
// Note stack built as a row of shifting cells; cell 0 is the top of stack.
// ----------------------------------------------------------------------------
module lnp_stack #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lnp_pkg::lnp_shift_t        shift,
  input  logic [lnp_pkg::NOTE_W-1:0] push_note,
  output lnp_pkg::lnp_stack_status_t status
);
  import lnp_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [NOTE_W-1:0] notes [STACK_DEPTH];
  logic              full;
  logic              empty;
  lnp_shift_t        cell_shift;

  assign full  = (count_r == CNT_W'(STACK_DEPTH));
  assign empty = (count_r == '0);

  // a push onto a full stack is dropped, a pop of an empty one does nothing
  assign cell_shift.push = shift.push && !full;
  assign cell_shift.pop  = shift.pop && !empty && !shift.push;

  always_comb begin
    count_nxt = count_r;
    if (cell_shift.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cell_shift.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [NOTE_W-1:0] above;
    logic [NOTE_W-1:0] below;
    if (i == 0) begin : g_top
      assign above = push_note;
    end else begin : g_mid
      assign above = notes[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_inner
      assign below = notes[i+1];
    end
    lnp_cell u_cell (
      .clk        (clk),
      .shift      (cell_shift),
      .above_note (above),
      .below_note (below),
      .note       (notes[i])
    );
  end

  assign status.empty = empty;
  assign status.full  = full;
  assign status.top   = notes[0];

endmodule

### sv/lnp_tone.sv
// ----------------------------------------------------------------------------
// lnp_tone
// Square-wave generator: picks the half-period from the table and runs the
// tick counter once per timer tick.
// ----------------------------------------------------------------------------
module lnp_tone (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lnp_pkg::lnp_tone_req_t  req,
  output lnp_pkg::lnp_tone_stat_t stat
);
  import lnp_pkg::*;

  logic [PERIOD_W-1:0] count_r;
  logic [PERIOD_W-1:0] count_nxt;
  logic [PERIOD_W-1:0] cmp_r;
  logic [PERIOD_W-1:0] cmp_nxt;
  logic                wave_r;
  logic                wave_nxt;
  logic                on_r;
  logic                on_nxt;
  logic [PERIOD_W-1:0] count_inc;

  assign count_inc = count_r + PERIOD_W'(1);

  always_comb begin
    count_nxt = count_r;
    cmp_nxt   = cmp_r;
    wave_nxt  = wave_r;
    on_nxt    = on_r;
    if (req.step) begin
      on_nxt = req.on;
      if (req.on) begin
        cmp_nxt = period_lookup(req.octave, req.note);
        if (count_inc == cmp_nxt) begin
          wave_nxt  = !wave_r;
          count_nxt = '0;
        end else begin
          count_nxt = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cmp_r   <= '0;
      wave_r  <= 1'b0;
      on_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      cmp_r   <= cmp_nxt;
      wave_r  <= wave_nxt;
      on_r    <= on_nxt;
    end
  end

  assign stat.wave        = wave_r;
  assign stat.on          = on_r;
  assign stat.half_period = cmp_r;

endmodule

### sv/last_note_priority_tone_generator.sv
// ----------------------------------------------------------------------------
// last_note_priority_tone_generator
// Monophonic square-wave tone generator with last-note priority.
// ----------------------------------------------------------------------------
// Each input transaction is one timer tick: the 13 debounced key levels and
// one-shot octave down/up pulses. Each tick gives exactly one output
// transaction with the wave level, tone enable, active note, octave and the
// half-period in use.
// The octave is updated at accept. Keys are then scanned one per cycle, each
// newly pressed key shifting into the top cell of the note stack. Keys no
// longer held are then popped from the top, one per cycle, until a held key
// is on top or the stack is empty (up to STACK_DEPTH pops). The tone counter
// is then stepped, and the output register is loaded once it is free.
// in_stall is high while an item is in work, so a new tick is taken only
// after the previous item has been loaded into the output register.
// A finished result waits in the output register while out_stall is high; the
// block may take the next tick meanwhile and holds before its own load.
// Reset (rst_n low, synchronous) empties the stack, clears the held keys,
// counter, half-period and wave, and sets the middle octave.
// ----------------------------------------------------------------------------
module last_note_priority_tone_generator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lnp_pkg::lnp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lnp_pkg::lnp_out_t out_data
);
  import lnp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KEYS = 3'd1;
  localparam logic [2:0] ST_POP  = 3'd2;
  localparam logic [2:0] ST_TONE = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  logic [NUM_KEYS-1:0] keys_r;
  logic [NUM_KEYS-1:0] keys_nxt;
  logic [NUM_KEYS-1:0] held_r;
  logic [NUM_KEYS-1:0] held_nxt;
  logic [NOTE_W-1:0]   key_idx_r;
  logic [NOTE_W-1:0]   key_idx_nxt;
  logic [OCT_W-1:0]    octave_r;
  logic [OCT_W-1:0]    octave_nxt;
  logic [OCT_W-1:0]    octave_dn;
  logic                out_valid_r;
  logic                out_valid_nxt;
  lnp_out_t            out_data_r;
  lnp_out_t            out_data_nxt;

  lnp_shift_t          shift;
  lnp_stack_status_t   stk;
  lnp_tone_req_t       tone_req;
  lnp_tone_stat_t      tone_stat;
  logic                slot_free;
  logic                top_held;

  assign slot_free = !out_valid_r || !out_stall;
  assign top_held  = (stk.top < NOTE_W'(NUM_KEYS)) && held_r[stk.top];

  // down step first, then up, each wrapping
  assign octave_dn = !in_data.octave_down ? octave_r :
                     (octave_r == '0) ? OCT_MAX : octave_r - OCT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    keys_nxt      = keys_r;
    held_nxt      = held_r;
    key_idx_nxt   = key_idx_r;
    octave_nxt    = octave_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    shift         = '0;
    tone_req      = '0;
    tone_req.on     = !stk.empty;
    tone_req.note   = stk.top;
    tone_req.octave = octave_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          keys_nxt    = in_data.key_levels;
          key_idx_nxt = '0;
          if (in_data.octave_up) begin
            octave_nxt = (octave_dn == OCT_MAX) ? '0 : octave_dn + OCT_W'(1);
          end else begin
            octave_nxt = octave_dn;
          end
          state_nxt = ST_KEYS;
        end
      end
      ST_KEYS: begin
        shift.push  = keys_r[key_idx_r] && !held_r[key_idx_r];
        key_idx_nxt = key_idx_r + NOTE_W'(1);
        if (key_idx_r == LAST_KEY) begin
          held_nxt  = keys_r;
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (!stk.empty && !top_held) begin
          shift.pop = 1'b1;
        end else begin
          state_nxt = ST_TONE;
        end
      end
      ST_TONE: begin
        tone_req.step = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.wave_out      = tone_stat.wave;
          out_data_nxt.tone_enabled  = tone_stat.on;
          out_data_nxt.active_note   = tone_stat.on ? stk.top : '0;
          out_data_nxt.active_octave = octave_r;
          out_data_nxt.half_period   = tone_stat.half_period;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      key_idx_r   <= '0;
      octave_r    <= OCT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      key_idx_r   <= key_idx_nxt;
      octave_r    <= octave_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    keys_r     <= keys_nxt;
    out_data_r <= out_data_nxt;
  end

  lnp_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift     (shift),
    .push_note (key_idx_r),
    .status    (stk)
  );

  lnp_tone u_tone (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tone_req),
    .stat  (tone_stat)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
